/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("%m: assertion failed");
// antecedent implies consequent at the following clock edge
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hdl/sbqeq_pkg.sv */
// ----------------------------------------------------------------------------
// sbqeq_pkg
// Types, constants and helpers for the stereo biquad cascade equaliser.
// ----------------------------------------------------------------------------
package sbqeq_pkg;

	localparam int NUM_STAGES      = 3;
	localparam int NUM_CHANNELS    = 2;
	localparam int SAMPLE_BITS     = 24;
	localparam int COEFF_FRAC_BITS = 28;

	localparam int WORD_W   = 32;
	localparam int ACC_W    = 64;
	localparam int NUM_TAPS = 5;
	localparam int NCOEF    = NUM_TAPS * NUM_STAGES;
	localparam int NROWS    = NUM_CHANNELS * NUM_STAGES;

	localparam int CIDX_W = $clog2(NCOEF);
	localparam int ROW_W  = (NROWS > 1) ? $clog2(NROWS) : 1;
	localparam int ST_W   = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
	localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int TAP_W  = $clog2(NUM_TAPS);

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	// one biquad stage of history: inputs x1, x2 and outputs y1, y2
	typedef struct packed {
		word_t x1;
		word_t x2;
		word_t y1;
		word_t y2;
	} hist_row_t;

	typedef enum logic [1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_COEF   = 2'd1,
		REQ_COMMIT = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic issue;
		logic finish;
		logic out_load;
	} ctrl_t;

	localparam acc_t  ROUND_BIAS = acc_t'(64'sd1 <<< (COEFF_FRAC_BITS - 1));
	localparam acc_t  W_MAX      = acc_t'(64'sd2147483647);
	localparam acc_t  W_MIN      = -W_MAX - acc_t'(1);
	localparam word_t S_MAX      = word_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam word_t S_MIN      = -S_MAX - word_t'(1);

	function automatic acc_t sat_add(acc_t a, acc_t b);
		logic signed [ACC_W:0] sum;
		sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (sum[ACC_W] != sum[ACC_W-1])
			return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return sum[ACC_W-1:0];
	endfunction

endpackage

/* hdl/stereo_biquad_cascade_eq_core.sv */
// ----------------------------------------------------------------------------
// stereo_biquad_cascade_eq_core
// Stereo direct-form-1 biquad cascade on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per item:
//   a sample pair, a shadow coefficient write, or a commit of the shadow bank.
//   Output channel (out_valid / out_stall) carries one filtered pair per
//   sample item; writes and commits produce nothing on it.
//   Writes and commits are taken in the idle state. A sample pair runs through one 32x32
//   multiplier, one product per cycle: each stage issues its five products,
//   then passes a drain state and a rounding state, for each stage of each
//   channel in turn. in_stall is high after acceptance until the sequencer
//   is back in idle, and the result is loaded after the last stage of the
//   last channel is rounded.
//   The result register sits on the output, so the next item is taken while
//   an earlier result still waits; a result that finds the register full
//   holds the sequencer until it is taken.
//   A block_start sample with a committed bank pending loads it into the
//   active bank before filtering.
//   Reset clears both coefficient banks, all filter history, the pending
//   mark and the output valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_biquad_cascade_eq_core
	import sbqeq_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic                          block_start,
	input  logic [3:0]                    coeff_index,
	input  logic signed [31:0]            coeff_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          clipped
);

	state_t    state_q, state_d;
	ctrl_t     ctrl;

	word_t     act_q [NCOEF];
	word_t     shd_q [NCOEF];
	hist_row_t hist_q [NROWS];
	logic      swap_pending_q;

	logic [CH_W-1:0]  ch_q;
	logic [ST_W-1:0]  stage_q;
	logic [TAP_W-1:0] tap_q;
	word_t            x_q, rsamp_q, left_fin_q, ylast_q;
	acc_t             acc_q, prod_s1;
	logic             prod_vld_s1;
	logic             out_valid_q;

	logic             in_acc;
	logic             last_tap, last_stage, last_ch;
	logic [CIDX_W-1:0] cidx;
	logic [ROW_W-1:0]  row_idx;
	hist_row_t        row;
	word_t            coef_sel, op_sel, y_d;
	acc_t             rnd, shr;

	function automatic logic signed [SAMPLE_BITS-1:0] to_sample(word_t v);
		if (v > S_MAX)
			return S_MAX[SAMPLE_BITS-1:0];
		if (v < S_MIN)
			return S_MIN[SAMPLE_BITS-1:0];
		return v[SAMPLE_BITS-1:0];
	endfunction

	assign in_acc     = in_valid && !in_stall;
	assign last_tap   = (tap_q == TAP_W'(NUM_TAPS - 1));
	assign last_stage = (stage_q == ST_W'(NUM_STAGES - 1));
	assign last_ch    = (ch_q == CH_W'(NUM_CHANNELS - 1));

	assign cidx    = CIDX_W'(int'(stage_q) * NUM_TAPS + int'(tap_q));
	assign row_idx = ROW_W'(int'(ch_q) * NUM_STAGES + int'(stage_q));
	assign row     = hist_q[row_idx];

	always_comb begin
		coef_sel = act_q[cidx];
		case (tap_q)
			TAP_W'(0): op_sel = x_q;
			TAP_W'(1): op_sel = row.x1;
			TAP_W'(2): op_sel = row.x2;
			TAP_W'(3): op_sel = row.y1;
			default:   op_sel = row.y2;
		endcase
	end

	// round half up, then clamp the stage output to 32 bits
	always_comb begin
		rnd = sat_add(acc_q, ROUND_BIAS);
		shr = rnd >>> COEFF_FRAC_BITS;
		if (shr > W_MAX)
			y_d = W_MAX[WORD_W-1:0];
		else if (shr < W_MIN)
			y_d = W_MIN[WORD_W-1:0];
		else
			y_d = shr[WORD_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && req_type == REQ_SAMPLE)
					state_d = ST_MAC;
			end
			ST_MAC: begin
				if (last_tap)
					state_d = ST_DRAIN;
			end
			ST_DRAIN:  state_d = ST_FINISH;
			ST_FINISH: begin
				if (last_stage && last_ch)
					state_d = ST_OUT;
				else
					state_d = ST_MAC;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		ctrl     = '0;
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_MAC:    ctrl.issue = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: ctrl.finish = 1'b1;
			ST_OUT:    ctrl.out_load = !out_valid_q || !out_stall;
			default:   in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request handling: banks and pending mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCOEF; i++) begin
				act_q[i] <= '0;
				shd_q[i] <= '0;
			end
			swap_pending_q <= 1'b0;
		end else if (in_acc) begin
			case (req_type)
				REQ_COEF: begin
					if (int'(coeff_index) < NCOEF)
						shd_q[CIDX_W'(coeff_index)] <= coeff_value;
					swap_pending_q <= 1'b0;
				end
				REQ_COMMIT: swap_pending_q <= 1'b1;
				REQ_SAMPLE: begin
					if (block_start && swap_pending_q) begin
						act_q          <= shd_q;
						swap_pending_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// multiplier and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
			tap_q       <= '0;
		end else begin
			prod_vld_s1 <= ctrl.issue;
			if (ctrl.issue)
				tap_q <= last_tap ? '0 : tap_q + TAP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue)
			prod_s1 <= acc_t'(coef_sel) * acc_t'(op_sel);
		if (in_acc || ctrl.finish)
			acc_q <= '0;
		else if (prod_vld_s1)
			acc_q <= sat_add(acc_q, prod_s1);
	end

	// stage and channel walk, history update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q    <= '0;
			stage_q <= '0;
			for (int r = 0; r < NROWS; r++)
				hist_q[r] <= '0;
		end else if (in_acc && req_type == REQ_SAMPLE) begin
			ch_q    <= '0;
			stage_q <= '0;
		end else if (ctrl.finish) begin
			hist_q[row_idx] <= '{x1: x_q, x2: row.x1, y1: y_d, y2: row.y1};
			if (last_stage) begin
				stage_q <= '0;
				ch_q    <= last_ch ? '0 : ch_q + CH_W'(1);
			end else begin
				stage_q <= stage_q + ST_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && req_type == REQ_SAMPLE) begin
			x_q     <= word_t'(left_sample);
			rsamp_q <= word_t'(right_sample);
		end else if (ctrl.finish) begin
			if (last_stage) begin
				x_q <= rsamp_q;
				if (last_ch)
					ylast_q <= y_d;
				else
					left_fin_q <= y_d;
			end else begin
				x_q <= y_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			if (NUM_CHANNELS > 1) begin
				left_out  <= to_sample(left_fin_q);
				right_out <= to_sample(ylast_q);
				clipped   <= (left_fin_q > S_MAX) || (left_fin_q < S_MIN) ||
					(ylast_q > S_MAX) || (ylast_q < S_MIN);
			end else begin
				left_out  <= to_sample(ylast_q);
				right_out <= '0;
				clipped   <= (ylast_q > S_MAX) || (ylast_q < S_MIN);
			end
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_ALWAYS(a_prod_consumed, clk, arst_n,
		!prod_vld_s1 || state_q == ST_MAC || state_q == ST_DRAIN)
	`ASSERT_ALWAYS(a_tap_range, clk, arst_n, tap_q < TAP_W'(NUM_TAPS))
	`ASSERT_NEXT(a_coef_clears_pending, clk, arst_n,
		in_acc && req_type == REQ_COEF, !swap_pending_q)
	`ASSERT_NEXT(a_sample_starts, clk, arst_n,
		in_acc && req_type == REQ_SAMPLE, state_q == ST_MAC && tap_q == '0 && !prod_vld_s1)
	`ASSERT_NEXT(a_finish_clears_acc, clk, arst_n, ctrl.finish, acc_q == '0)

endmodule
